[hdl/edge_table_rcm_reorder_defines.svh]
// Assertion macros for the edge table / RCM ordering block
`ifndef EDGE_TABLE_RCM_REORDER_DEFINES_SVH
`define EDGE_TABLE_RCM_REORDER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ETRCM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ETRCM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ETRCM_ASSERT_IMP(lbl, ante, cons, msg)
`define ETRCM_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/etrcm_pkg.sv]
package etrcm_pkg;

    localparam int MAX_NODES = 1024;
    localparam int MAX_EDGES = 4096;

    localparam int NODE_W = 10;
    localparam int EDGE_W = 12;
    localparam int ITEM_W = 13;
    localparam int HEAD_W = 14;  // top bit marks an empty list
    localparam int DEG_W  = 13;
    localparam int POS_W  = 12;
    localparam int CNT_W  = 11;
    localparam int TOT_W  = 13;

    localparam logic [HEAD_W-1:0] HEAD_EMPTY   = 14'h2000;
    localparam logic [POS_W-1:0]  POS_UNVISITED = 12'hFFF;
    localparam logic [POS_W-1:0]  POS_QUEUED    = 12'hFFE;

    // opcodes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_ORDER = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EXISTS   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_SELF     = 3'd3;
    localparam logic [2:0] ST_ISOLATED = 3'd4;
    localparam logic [2:0] ST_NOT_DONE = 3'd5;

    // register index
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef struct packed {
        logic [HEAD_W-1:0] head;
        logic [DEG_W-1:0]  deg;
    } node_word_t;

    typedef struct packed {
        logic [NODE_W-1:0] n0;
        logic [NODE_W-1:0] n1;
    } edge_word_t;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [DEG_W-1:0]  deg;
    } queue_word_t;

    typedef struct packed {
        logic             wr;
        logic [CNT_W-1:0] node_count;
    } cfg_t;

endpackage

[hdl/etrcm_cfg.sv]
module etrcm_cfg
    import etrcm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [CNT_W-1:0] node_count_reg;
    logic [CNT_W-1:0] wval;
    logic             wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);

    // clamp written value into 1 .. MAX_NODES
    always_comb
    begin
        wval = pwdata[CNT_W-1:0];
        if (wval == '0)
            wval = CNT_W'(1);
        else if (wval > CNT_W'(MAX_NODES))
            wval = CNT_W'(MAX_NODES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_count_reg <= CNT_W'(MAX_NODES);
        else if (wr)
            node_count_reg <= wval;
    end

    assign prdata = (paddr[2] == REG_NODE_COUNT) ? {21'd0, node_count_reg} : 32'd0;
    assign cfg.wr = wr;
    assign cfg.node_count = node_count_reg;

endmodule

[hdl/edge_table_rcm_reorder.sv]
// Undirected edge table with reverse Cuthill-McKee ordering. One result per
// transfer. After reset the block clears every node memory entry before
// in_ready rises. An add walks the first endpoint's adjacency list to look
// for the edge. An ordering clears all positions, then runs one degree scan
// over node_count nodes per connected component, and for each numbered node
// walks its incident edges and passes queue entries in the sorted insert.
`include "edge_table_rcm_reorder_defines.svh"
module edge_table_rcm_reorder
    import etrcm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        opcode,
    input  logic [NODE_W-1:0] node_a,
    input  logic [NODE_W-1:0] node_b,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [EDGE_W-1:0] edge_index,
    output logic [TOT_W-1:0]  edge_total,
    output logic [NODE_W-1:0] old_node,
    output logic [NODE_W-1:0] new_position,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_OUT,
        A_HEAD, A_HEADW, A_WALK, A_CMP, A_LINKB,
        C_CLR, C_CHK, C_SCAN,
        N_START, N_HEAD, N_WALK, N_EDGE, N_SIDE, N_POS, N_DEG,
        N_INS, N_INSC, N_SH, N_SHW, N_PUT, N_SNEXT, N_DONE, N_DEQ,
        Q_RD, Q_WR
    } state_t;

    cfg_t cfg;

    etrcm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t            state_reg;
    logic [NODE_W-1:0] a_reg, b_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [HEAD_W-1:0] item_reg, nxt_reg;
    node_word_t        word_reg;
    logic [TOT_W-1:0]  total_reg;
    logic              valid_reg;
    logic [CNT_W-1:0]  numbered_reg, qlen_reg, nhere_reg, loc_reg, ins_reg, sh_reg;
    logic              pv_reg, have_reg, side_reg;
    logic [NODE_W-1:0] pidx_reg, best_reg, cur_reg, oth_reg;
    logic [DEG_W-1:0]  bestdeg_reg, newdeg_reg;
    edge_word_t        ep_reg;
    logic [2:0]        res_status_reg;
    logic [EDGE_W-1:0] res_eidx_reg;
    logic [NODE_W-1:0] res_old_reg, res_newp_reg;
    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [EDGE_W-1:0] eidx_reg;
    logic [TOT_W-1:0]  etot_reg;
    logic [NODE_W-1:0] oldn_reg, newp_reg;

    // memories
    node_word_t  node_mem [MAX_NODES];
    logic [HEAD_W-1:0] next_mem [2*MAX_EDGES];
    edge_word_t  edge_mem [MAX_EDGES];
    logic [POS_W-1:0]  pos_mem [MAX_NODES];
    logic [NODE_W-1:0] nap_mem [MAX_NODES];
    queue_word_t q_mem [MAX_NODES];

    logic node_we, next_we, edge_we, pos_we, nap_we, q_we;
    logic [NODE_W-1:0] node_wa, node_ra, pos_wa, pos_ra, nap_wa, nap_ra, q_wa, q_ra;
    logic [ITEM_W-1:0] next_wa, next_ra;
    logic [EDGE_W-1:0] edge_wa, edge_ra;
    node_word_t  node_wd, node_rd_reg;
    logic [HEAD_W-1:0] next_wd, next_rd_reg;
    edge_word_t  edge_wd, edge_rd_reg;
    logic [POS_W-1:0]  pos_wd, pos_rd_reg;
    logic [NODE_W-1:0] nap_wd, nap_rd_reg;
    queue_word_t q_wd, q_rd_reg;

    logic [NODE_W-1:0] other;
    logic [CNT_W-1:0]  qpos;

    assign other = side_reg ? ep_reg.n1 : ep_reg.n0;
    assign qpos  = CNT_W'(numbered_reg - CNT_W'(1) - {1'b0, a_reg});

    always_ff @(posedge clk)
    begin
        if (node_we) node_mem[node_wa] <= node_wd;
        node_rd_reg <= node_mem[node_ra];
    end

    always_ff @(posedge clk)
    begin
        if (next_we) next_mem[next_wa] <= next_wd;
        next_rd_reg <= next_mem[next_ra];
    end

    always_ff @(posedge clk)
    begin
        if (edge_we) edge_mem[edge_wa] <= edge_wd;
        edge_rd_reg <= edge_mem[edge_ra];
    end

    always_ff @(posedge clk)
    begin
        if (pos_we) pos_mem[pos_wa] <= pos_wd;
        pos_rd_reg <= pos_mem[pos_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nap_we) nap_mem[nap_wa] <= nap_wd;
        nap_rd_reg <= nap_mem[nap_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_we) q_mem[q_wa] <= q_wd;
        q_rd_reg <= q_mem[q_ra];
    end

    // memory addressing per state
    always_comb
    begin
        node_we = 1'b0; node_wa = '0; node_wd = '0; node_ra = '0;
        next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = '0;
        edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = '0;
        pos_we  = 1'b0; pos_wa  = '0; pos_wd  = '0; pos_ra  = '0;
        nap_we  = 1'b0; nap_wa  = '0; nap_wd  = '0; nap_ra  = '0;
        q_we    = 1'b0; q_wa    = '0; q_wd    = '0; q_ra    = '0;
        unique case (state_reg)
            S_CLR:
            begin
                node_we = 1'b1;
                node_wa = idx_reg[NODE_W-1:0];
                node_wd = '{head: HEAD_EMPTY, deg: '0};
            end
            A_HEAD: node_ra = a_reg;
            A_WALK:
            begin
                if (!item_reg[HEAD_W-1])
                begin
                    next_ra = item_reg[ITEM_W-1:0];
                    edge_ra = item_reg[ITEM_W-1:1];
                end
                else if (total_reg < TOT_W'(MAX_EDGES))
                begin
                    edge_we = 1'b1;
                    edge_wa = total_reg[EDGE_W-1:0];
                    edge_wd = '{n0: a_reg, n1: b_reg};
                    next_we = 1'b1;
                    next_wa = {total_reg[EDGE_W-1:0], 1'b0};
                    next_wd = word_reg.head;
                    node_we = 1'b1;
                    node_wa = a_reg;
                    node_wd = '{head: {1'b0, total_reg[EDGE_W-1:0], 1'b0},
                                deg: DEG_W'(word_reg.deg + DEG_W'(1))};
                    node_ra = b_reg;
                end
            end
            A_LINKB:
            begin
                next_we = 1'b1;
                next_wa = {total_reg[EDGE_W-1:0], 1'b1};
                next_wd = node_rd_reg.head;
                node_we = 1'b1;
                node_wa = b_reg;
                node_wd = '{head: {1'b0, total_reg[EDGE_W-1:0], 1'b1},
                            deg: DEG_W'(node_rd_reg.deg + DEG_W'(1))};
            end
            C_CLR:
            begin
                pos_we = 1'b1;
                pos_wa = idx_reg[NODE_W-1:0];
                pos_wd = POS_UNVISITED;
            end
            C_SCAN:
            begin
                pos_ra  = idx_reg[NODE_W-1:0];
                node_ra = idx_reg[NODE_W-1:0];
            end
            N_START:
            begin
                if (numbered_reg < CNT_W'(MAX_NODES))
                begin
                    nap_we = 1'b1;
                    nap_wa = numbered_reg[NODE_W-1:0];
                    nap_wd = cur_reg;
                    pos_we = 1'b1;
                    pos_wa = cur_reg;
                    pos_wd = {1'b0, numbered_reg};
                end
                node_ra = cur_reg;
            end
            N_WALK:
            begin
                next_ra = item_reg[ITEM_W-1:0];
                edge_ra = item_reg[ITEM_W-1:1];
            end
            N_SIDE: pos_ra = other;
            N_POS:
            begin
                if (pos_rd_reg == POS_UNVISITED)
                begin
                    pos_we = 1'b1;
                    pos_wa = oth_reg;
                    pos_wd = POS_QUEUED;
                end
                node_ra = oth_reg;
            end
            N_INS: q_ra = loc_reg[NODE_W-1:0];
            N_SH:  q_ra = NODE_W'(sh_reg - CNT_W'(1));
            N_SHW:
            begin
                q_we = 1'b1;
                q_wa = sh_reg[NODE_W-1:0];
                q_wd = q_rd_reg;
            end
            N_PUT:
            begin
                q_we = 1'b1;
                q_wa = ins_reg[NODE_W-1:0];
                q_wd = '{node: oth_reg, deg: newdeg_reg};
            end
            N_DONE: q_ra = NODE_W'(qlen_reg - CNT_W'(1));
            Q_RD:
            begin
                nap_ra = qpos[NODE_W-1:0];
                pos_ra = a_reg;
            end
            default: ;
        endcase
    end

    // control sequencer and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            a_reg          <= '0;
            b_reg          <= '0;
            idx_reg        <= '0;
            item_reg       <= HEAD_EMPTY;
            nxt_reg        <= HEAD_EMPTY;
            word_reg       <= '0;
            total_reg      <= '0;
            valid_reg      <= 1'b0;
            numbered_reg   <= '0;
            qlen_reg       <= '0;
            nhere_reg      <= '0;
            loc_reg        <= '0;
            ins_reg        <= '0;
            sh_reg         <= '0;
            pv_reg         <= 1'b0;
            have_reg       <= 1'b0;
            side_reg       <= 1'b0;
            pidx_reg       <= '0;
            best_reg       <= '0;
            cur_reg        <= '0;
            oth_reg        <= '0;
            bestdeg_reg    <= '0;
            newdeg_reg     <= '0;
            ep_reg         <= '0;
            res_status_reg <= ST_OK;
            res_eidx_reg   <= '0;
            res_old_reg    <= '0;
            res_newp_reg   <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_OK;
            eidx_reg       <= '0;
            etot_reg       <= '0;
            oldn_reg       <= '0;
            newp_reg       <= '0;
        end
        else
        begin
            // S_OUT reloads the output register itself
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_CLR:
                begin
                    idx_reg <= CNT_W'(idx_reg + CNT_W'(1));
                    if (idx_reg == CNT_W'(MAX_NODES - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        a_reg          <= node_a;
                        b_reg          <= node_b;
                        res_eidx_reg   <= '0;
                        res_old_reg    <= '0;
                        res_newp_reg   <= '0;
                        case (opcode)
                            OP_ADD:
                            begin
                                if (node_a == node_b)
                                begin
                                    res_status_reg <= ST_SELF;
                                    state_reg      <= S_OUT;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                    state_reg      <= A_HEAD;
                                end
                            end
                            OP_ORDER:
                            begin
                                res_status_reg <= ST_OK;
                                idx_reg        <= '0;
                                valid_reg      <= 1'b0;
                                state_reg      <= C_CLR;
                            end
                            OP_QUERY:
                            begin
                                if (!valid_reg)
                                begin
                                    res_status_reg <= ST_NOT_DONE;
                                    state_reg      <= S_OUT;
                                end
                                else
                                begin
                                    res_status_reg <= ST_OK;
                                    if ({1'b0, node_a} < cfg.node_count)
                                        state_reg <= Q_RD;
                                    else
                                        state_reg <= S_OUT;
                                end
                            end
                            default:
                            begin
                                res_status_reg <= ST_OK;
                                state_reg      <= S_OUT;
                            end
                        endcase
                    end
                    else if (cfg.wr)
                        valid_reg <= 1'b0;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        eidx_reg      <= res_eidx_reg;
                        etot_reg      <= total_reg;
                        oldn_reg      <= res_old_reg;
                        newp_reg      <= res_newp_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                // edge insertion
                A_HEAD: state_reg <= A_HEADW;
                A_HEADW:
                begin
                    word_reg  <= node_rd_reg;
                    item_reg  <= node_rd_reg.head;
                    state_reg <= A_WALK;
                end
                A_WALK:
                begin
                    if (!item_reg[HEAD_W-1])
                        state_reg <= A_CMP;
                    else if (total_reg >= TOT_W'(MAX_EDGES))
                    begin
                        res_status_reg <= ST_FULL;
                        state_reg      <= S_OUT;
                    end
                    else
                        state_reg <= A_LINKB;
                end
                A_CMP:
                begin
                    if ((edge_rd_reg.n0 == a_reg && edge_rd_reg.n1 == b_reg) ||
                        (edge_rd_reg.n0 == b_reg && edge_rd_reg.n1 == a_reg))
                    begin
                        res_status_reg <= ST_EXISTS;
                        res_eidx_reg   <= item_reg[ITEM_W-1:1];
                        state_reg      <= S_OUT;
                    end
                    else
                    begin
                        item_reg  <= next_rd_reg;
                        state_reg <= A_WALK;
                    end
                end
                A_LINKB:
                begin
                    res_eidx_reg <= total_reg[EDGE_W-1:0];
                    total_reg    <= TOT_W'(total_reg + TOT_W'(1));
                    valid_reg    <= 1'b0;
                    state_reg    <= S_OUT;
                end
                // ordering: clear positions
                C_CLR:
                begin
                    idx_reg <= CNT_W'(idx_reg + CNT_W'(1));
                    if (idx_reg == CNT_W'(MAX_NODES - 1))
                    begin
                        numbered_reg <= '0;
                        qlen_reg     <= '0;
                        state_reg    <= C_CHK;
                    end
                end
                C_CHK:
                begin
                    if (numbered_reg >= cfg.node_count)
                    begin
                        valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        pv_reg    <= 1'b0;
                        have_reg  <= 1'b0;
                        state_reg <= C_SCAN;
                    end
                end
                // start node search, one node a cycle
                C_SCAN:
                begin
                    if (pv_reg && pos_rd_reg == POS_UNVISITED && node_rd_reg.deg != '0 &&
                        (!have_reg || node_rd_reg.deg < bestdeg_reg))
                    begin
                        have_reg    <= 1'b1;
                        best_reg    <= pidx_reg;
                        bestdeg_reg <= node_rd_reg.deg;
                    end
                    if (idx_reg < cfg.node_count)
                    begin
                        idx_reg  <= CNT_W'(idx_reg + CNT_W'(1));
                        pidx_reg <= idx_reg[NODE_W-1:0];
                        pv_reg   <= 1'b1;
                    end
                    else
                    begin
                        pv_reg <= 1'b0;
                        if (!pv_reg)
                        begin
                            if (have_reg)
                            begin
                                cur_reg   <= best_reg;
                                state_reg <= N_START;
                            end
                            else
                            begin
                                res_status_reg <= ST_ISOLATED;
                                state_reg      <= S_OUT;
                            end
                        end
                    end
                end
                // number one node and queue its neighbours
                N_START:
                begin
                    if (numbered_reg < CNT_W'(MAX_NODES))
                    begin
                        numbered_reg <= CNT_W'(numbered_reg + CNT_W'(1));
                        nhere_reg    <= '0;
                        state_reg    <= N_HEAD;
                    end
                    else
                        state_reg <= N_DONE;
                end
                N_HEAD:
                begin
                    item_reg  <= node_rd_reg.head;
                    state_reg <= N_WALK;
                end
                N_WALK:
                begin
                    if (item_reg[HEAD_W-1])
                        state_reg <= N_DONE;
                    else
                        state_reg <= N_EDGE;
                end
                N_EDGE:
                begin
                    ep_reg    <= edge_rd_reg;
                    nxt_reg   <= next_rd_reg;
                    side_reg  <= 1'b0;
                    state_reg <= N_SIDE;
                end
                N_SIDE:
                begin
                    oth_reg <= other;
                    if ({1'b0, other} < cfg.node_count)
                        state_reg <= N_POS;
                    else
                        state_reg <= N_SNEXT;
                end
                N_POS:
                begin
                    if (pos_rd_reg == POS_UNVISITED)
                        state_reg <= N_DEG;
                    else
                        state_reg <= N_SNEXT;
                end
                N_DEG:
                begin
                    newdeg_reg <= node_rd_reg.deg;
                    if (qlen_reg >= CNT_W'(MAX_NODES))
                        state_reg <= N_SNEXT;
                    else
                    begin
                        loc_reg   <= '0;
                        ins_reg   <= nhere_reg;
                        state_reg <= N_INS;
                    end
                end
                // sorted insert into the current batch
                N_INS:
                begin
                    if (loc_reg < nhere_reg)
                        state_reg <= N_INSC;
                    else
                    begin
                        sh_reg    <= qlen_reg;
                        state_reg <= N_SH;
                    end
                end
                N_INSC:
                begin
                    if (q_rd_reg.deg < newdeg_reg)
                    begin
                        ins_reg   <= loc_reg;
                        sh_reg    <= qlen_reg;
                        state_reg <= N_SH;
                    end
                    else
                    begin
                        loc_reg   <= CNT_W'(loc_reg + CNT_W'(1));
                        state_reg <= N_INS;
                    end
                end
                N_SH:
                begin
                    if (sh_reg > ins_reg)
                        state_reg <= N_SHW;
                    else
                        state_reg <= N_PUT;
                end
                N_SHW:
                begin
                    sh_reg    <= CNT_W'(sh_reg - CNT_W'(1));
                    state_reg <= N_SH;
                end
                N_PUT:
                begin
                    qlen_reg  <= CNT_W'(qlen_reg + CNT_W'(1));
                    nhere_reg <= CNT_W'(nhere_reg + CNT_W'(1));
                    state_reg <= N_SNEXT;
                end
                N_SNEXT:
                begin
                    if (!side_reg)
                    begin
                        side_reg  <= 1'b1;
                        state_reg <= N_SIDE;
                    end
                    else
                    begin
                        item_reg  <= nxt_reg;
                        state_reg <= N_WALK;
                    end
                end
                // serve the queue top
                N_DONE:
                begin
                    if (qlen_reg != '0)
                    begin
                        qlen_reg  <= CNT_W'(qlen_reg - CNT_W'(1));
                        state_reg <= N_DEQ;
                    end
                    else
                        state_reg <= C_CHK;
                end
                N_DEQ:
                begin
                    cur_reg   <= q_rd_reg.node;
                    state_reg <= N_START;
                end
                // query: numbering is stored forward, reversed on read
                Q_RD: state_reg <= Q_WR;
                Q_WR:
                begin
                    res_old_reg  <= nap_rd_reg;
                    res_newp_reg <= NODE_W'(numbered_reg - CNT_W'(1) -
                                            pos_rd_reg[CNT_W-1:0]);
                    state_reg    <= S_OUT;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign edge_index   = eidx_reg;
    assign edge_total   = etot_reg;
    assign old_node     = oldn_reg;
    assign new_position = newp_reg;

    `ETRCM_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
    `ETRCM_ASSERT_IMP(a_total_bound, 1'b1, total_reg <= TOT_W'(MAX_EDGES), "edge count overflow")
    `ETRCM_ASSERT_IMP(a_queue_bound, 1'b1, qlen_reg <= CNT_W'(MAX_NODES), "queue overflow")
    `ETRCM_ASSERT_IMP(a_valid_full, valid_reg, numbered_reg == cfg.node_count, "partial ordering")

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import etrcm_pkg::*;

    typedef struct packed {
        logic [2:0]        status;
        logic [EDGE_W-1:0] edge_index;
        logic [TOT_W-1:0]  edge_total;
        logic [NODE_W-1:0] old_node;
        logic [NODE_W-1:0] new_position;
    } rcm_result_t;

    // Mirror of the edge table and RCM ordering, plus the store of awaited results
    class rcm_scoreboard;
        int                node_limit;
        logic [NODE_W-1:0] end0 [MAX_EDGES];
        logic [NODE_W-1:0] end1 [MAX_EDGES];
        int                edges_stored;
        int                adj_head [MAX_NODES];
        int                adj_next [2*MAX_EDGES];
        int                adj_edge [2*MAX_EDGES];
        int                degree [MAX_NODES];
        logic [POS_W-1:0]  position [MAX_NODES];
        int                placed [MAX_NODES];
        int                bfs_node [MAX_NODES];
        int                bfs_deg [MAX_NODES];
        int                bfs_len;
        int                numbered;
        bit                order_ok;
        rcm_result_t       awaited [$];
        int                errors;

        function new();
            node_limit   = MAX_NODES;
            edges_stored = 0;
            bfs_len      = 0;
            numbered     = 0;
            order_ok     = 0;
            errors       = 0;
            for (int i = 0; i < MAX_NODES; i++)
            begin
                adj_head[i] = -1;
                degree[i]   = 0;
                position[i] = POS_UNVISITED;
            end
        endfunction

        // register write: clamp to 1 .. MAX_NODES, invalidates ordering
        function void write_node_count(logic [31:0] value);
            int v;
            v = value & 32'h7FF;
            if (v == 0)
                v = 1;
            if (v > MAX_NODES)
                v = MAX_NODES;
            node_limit = v;
            order_ok   = 0;
        endfunction

        function bit find_edge(int a, int b, output int found);
            int item;
            item  = adj_head[a];
            found = 0;
            while (item >= 0)
            begin
                int e;
                e = adj_edge[item];
                if ((end0[e] == a && end1[e] == b) || (end0[e] == b && end1[e] == a))
                begin
                    found = e;
                    return 1;
                end
                item = adj_next[item];
            end
            return 0;
        endfunction

        function void link(int node, int item, int e);
            adj_edge[item] = e;
            adj_next[item] = adj_head[node];
            adj_head[node] = item;
            degree[node]++;
        endfunction

        // sorted insert into the current batch, descending degree
        function void enqueue(int node, int d, inout int in_batch);
            int ins;
            if (bfs_len >= MAX_NODES)
                return;
            ins = in_batch;
            for (int k = 0; k < in_batch; k++)
            begin
                if (bfs_deg[k] < d)
                begin
                    ins = k;
                    break;
                end
            end
            for (int k = bfs_len; k > ins; k--)
            begin
                bfs_node[k] = bfs_node[k-1];
                bfs_deg[k]  = bfs_deg[k-1];
            end
            bfs_node[ins] = node;
            bfs_deg[ins]  = d;
            bfs_len++;
            in_batch++;
        endfunction

        function void number_node(int node);
            int in_batch;
            int item;
            in_batch = 0;
            if (numbered >= MAX_NODES)
                return;
            placed[numbered] = node;
            position[node]   = POS_W'(numbered);
            numbered++;
            item = adj_head[node];
            while (item >= 0)
            begin
                int e;
                int nb;
                e = adj_edge[item];
                for (int s = 0; s < 2; s++)
                begin
                    nb = (s == 0) ? end0[e] : end1[e];
                    if (nb < node_limit && position[nb] == POS_UNVISITED)
                    begin
                        position[nb] = POS_QUEUED;
                        enqueue(nb, degree[nb], in_batch);
                    end
                end
                item = adj_next[item];
            end
        endfunction

        function logic [2:0] compute_order();
            int t;
            order_ok = 0;
            for (int i = 0; i < MAX_NODES; i++)
                position[i] = POS_UNVISITED;
            numbered = 0;
            bfs_len  = 0;
            while (numbered < node_limit)
            begin
                int best;
                int best_deg;
                bit have;
                best = 0;
                best_deg = 0;
                have = 0;
                for (int i = 0; i < node_limit; i++)
                begin
                    if (position[i] == POS_UNVISITED && degree[i] > 0 &&
                        (!have || degree[i] < best_deg))
                    begin
                        best     = i;
                        best_deg = degree[i];
                        have     = 1;
                    end
                end
                if (!have)
                    return ST_ISOLATED;
                number_node(best);
                while (bfs_len > 0)
                begin
                    bfs_len--;
                    number_node(bfs_node[bfs_len]);
                end
            end
            for (int i = 0; i < numbered / 2; i++)
            begin
                t = placed[i];
                placed[i] = placed[numbered-1-i];
                placed[numbered-1-i] = t;
            end
            for (int i = 0; i < numbered; i++)
                position[placed[i]] = POS_W'(i);
            order_ok = 1;
            return ST_OK;
        endfunction

        // accepted input transfer: predict its result
        function void note_input(logic [1:0] op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
            rcm_result_t r;
            int found;
            r = '0;
            if (op == OP_ADD)
            begin
                if (a == b)
                    r.status = ST_SELF;
                else if (find_edge(a, b, found))
                begin
                    r.status     = ST_EXISTS;
                    r.edge_index = EDGE_W'(found);
                end
                else if (edges_stored >= MAX_EDGES)
                    r.status = ST_FULL;
                else
                begin
                    end0[edges_stored] = a;
                    end1[edges_stored] = b;
                    link(a, 2*edges_stored, edges_stored);
                    link(b, 2*edges_stored + 1, edges_stored);
                    r.edge_index = EDGE_W'(edges_stored);
                    edges_stored++;
                    order_ok = 0;
                end
            end
            else if (op == OP_ORDER)
                r.status = compute_order();
            else if (op == OP_QUERY)
            begin
                if (!order_ok)
                    r.status = ST_NOT_DONE;
                else if (a < node_limit)
                begin
                    r.old_node     = NODE_W'(placed[a]);
                    r.new_position = NODE_W'(position[a]);
                end
            end
            r.edge_total = TOT_W'(edges_stored);
            awaited.push_back(r);
        endfunction

        function void check_result(rcm_result_t got);
            rcm_result_t w;
            if (awaited.size() == 0)
            begin
                $error("result transfer with nothing awaited");
                errors++;
                return;
            end
            w = awaited.pop_front();
            if (got.status !== w.status)
            begin
                $error("status: expected %0d, got %0d", w.status, got.status);
                errors++;
            end
            if (got.edge_index !== w.edge_index)
            begin
                $error("edge_index: expected %0d, got %0d", w.edge_index, got.edge_index);
                errors++;
            end
            if (got.edge_total !== w.edge_total)
            begin
                $error("edge_total: expected %0d, got %0d", w.edge_total, got.edge_total);
                errors++;
            end
            if (got.old_node !== w.old_node)
            begin
                $error("old_node: expected %0d, got %0d", w.old_node, got.old_node);
                errors++;
            end
            if (got.new_position !== w.new_position)
            begin
                $error("new_position: expected %0d, got %0d", w.new_position, got.new_position);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        opcode;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
    logic              out_valid;
    logic              out_ready;
    logic [2:0]        status;
    logic [EDGE_W-1:0] edge_index;
    logic [TOT_W-1:0]  edge_total;
    logic [NODE_W-1:0] old_node;
    logic [NODE_W-1:0] new_position;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    rcm_scoreboard sb;
    int  burst_left;
    int  sent;
    bit  hold_req;

    edge_table_rcm_reorder dut (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    initial
    begin
        #200ms;
        $display("tb_top NOT OK");
        $finish;
    end

    // one input transfer, with random bursts and gaps
    task automatic send_item(logic [1:0] op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 10);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        node_a   <= a;
        node_b   <= b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(op, a, b);
        sent++;
        burst_left--;
        @(negedge clk);
    endtask

    // stop offering and wait until every awaited result has arrived
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_node_count(logic [31:0] value);
        drain();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 3'(4 * REG_NODE_COUNT);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.write_node_count(value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // receiver: stall pattern changes every so often; long hold on request
    initial
    begin
        int mode;
        int tick;
        out_ready = 1'b0;
        mode = 0;
        tick = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (3000) @(negedge clk);
                hold_req = 0;
            end
            tick++;
            if (tick % 200 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= $urandom_range(0, 1);
                2: out_ready <= (tick % 4 == 0);
                default: out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                sb.check_result({status, edge_index, edge_total, old_node, new_position});
        end
    end

    initial
    begin
        int nc;
        int j;
        int rounds;
        sb = new();
        in_valid   = 1'b0;
        opcode     = OP_ADD;
        node_a     = '0;
        node_b     = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        hold_req   = 0;
        burst_left = 0;
        sent       = 0;
        rst_n      = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: status codes, field extremes, clamped register values
        send_item(OP_QUERY, 10'd0, 10'd0);
        send_item(2'd3, 10'h3FF, 10'h3FF);
        send_item(OP_ADD, 10'd3, 10'd3);
        send_item(OP_ADD, 10'd0, 10'd1023);
        send_item(OP_ADD, 10'd1023, 10'd0);
        send_item(OP_ADD, 10'd0, 10'd1);
        send_item(OP_ADD, 10'd1, 10'd2);
        send_item(OP_ADD, 10'd2, 10'd0);
        send_item(OP_ADD, 10'd1, 10'd0);
        send_item(OP_ORDER, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd1, 10'd0);
        write_node_count(32'd0);
        send_item(OP_ORDER, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd5, 10'd0);
        write_node_count(32'd3);
        send_item(OP_ORDER, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd1, 10'd0);
        send_item(OP_QUERY, 10'd2, 10'd0);
        send_item(OP_QUERY, 10'd1023, 10'd0);
        send_item(OP_ADD, 10'd2, 10'd4);
        send_item(OP_QUERY, 10'd0, 10'd0);
        write_node_count(32'd2047);
        write_node_count(32'd1024);

        // random rounds: mostly connect every node in range, add extras, order, query
        rounds = 0;
        while (sent < 1400)
        begin
            rounds++;
            nc = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
            write_node_count(nc);
            if (rounds == 8)
                hold_req = 1;
            if ($urandom_range(0, 5) != 0)
            begin
                for (int i = 0; i < nc; i++)
                begin
                    if (sb.degree[i] == 0)
                    begin
                        j = $urandom_range(0, (nc > 1) ? nc - 1 : 1);
                        if (j == i)
                            j = i + 1;
                        send_item(OP_ADD, NODE_W'(i), NODE_W'(j));
                    end
                end
            end
            repeat ($urandom_range(0, 10))
            begin
                j = $urandom_range(0, nc + 2);
                send_item(OP_ADD, NODE_W'($urandom_range(0, nc + 2)), NODE_W'(j));
            end
            // noise, sometimes with full-range fields
            repeat ($urandom_range(0, 3))
            begin
                if ($urandom_range(0, 3) == 0)
                    send_item(2'($urandom_range(0, 3)), 10'($urandom), 10'($urandom));
                else
                    send_item(2'($urandom_range(0, 3)), 10'($urandom_range(0, 63)),
                              10'($urandom_range(0, 63)));
            end
            send_item(OP_ORDER, 10'($urandom), 10'($urandom));
            repeat ($urandom_range(4, 16))
            begin
                if ($urandom_range(0, 7) == 0)
                    send_item(OP_QUERY, 10'($urandom), 10'($urandom));
                else
                    send_item(OP_QUERY, NODE_W'($urandom_range(0, nc + 3)), 10'($urandom));
            end
        end

        // adds including a repeat in reversed orientation, then ordering over the full node range
        send_item(OP_ADD, 10'd5, 10'd700);
        send_item(OP_ADD, 10'd1, 10'd0);
        send_item(OP_ADD, 10'd1023, 10'd1022);
        write_node_count(32'd1024);
        send_item(OP_ORDER, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd0, 10'd0);
        send_item(OP_QUERY, 10'd1023, 10'd0);
        repeat (20)
            send_item(OP_QUERY, 10'($urandom), 10'($urandom));

        // end of run
        drain();
        repeat (100) @(negedge clk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/etrcm_pkg.sv
hdl/etrcm_cfg.sv
hdl/edge_table_rcm_reorder.sv
sim/tb_top.sv
